/* design/lsm_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// lsm_pkg
// Shared types and constants for the line substring matcher.
// ============================================================================
package lsm_pkg;

    localparam logic [7:0] SPACE_BYTE  = 8'h20;
    localparam logic [4:0] BYTES_SAT   = 5'd31;
    localparam int         CFG_IDX_W   = 3;
    localparam int         CFG_DATA_W  = 64;
    localparam int         PAT_BYTES   = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_LOW  = 3'd0,
        REG_PATTERN_HIGH = 3'd1,
        REG_PATTERN_LEN  = 3'd2,
        REG_IGNORE_CASE  = 3'd3,
        REG_WHOLE_WORD   = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       has_char;
        logic       line_end;
        logic       new_file;
    } in_word_t;

    typedef struct packed {
        logic        matched;
        logic [31:0] line_number;
        logic [31:0] match_count;
    } out_word_t;

    // pattern byte i sits in bits 8*i+7:8*i
    typedef struct packed {
        logic [8*PAT_BYTES-1:0] pattern;
        logic [4:0]             pattern_length;
        logic                   ignore_case;
        logic                   whole_word;
    } cfg_t;

    // pipeline stage handed to the per-line state logic
    typedef struct packed {
        logic     step;
        in_word_t word;
    } stage_t;

    function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic fold);
        logic [7:0] r;
        r = b;
        if (fold && b >= 8'h61 && b <= 8'h7A)
        begin
            r = b - 8'h20;
        end
        return r;
    endfunction

endpackage

/* design/lsm_match.sv */
`timescale 1ns / 1ps
// ============================================================================
// lsm_match
// Byte window, parallel pattern compare and per-line match flags.
// ============================================================================
module lsm_match #(
    parameter int PATTERN_MAX = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  lsm_pkg::cfg_t   cfg,
    input  lsm_pkg::stage_t stage,
    output logic            hit
);

    localparam int DEPTH = PATTERN_MAX + 1;
    localparam int IW    = $clog2(DEPTH);

    logic [7:0]    win_reg  [DEPTH];
    logic [7:0]    win_next [DEPTH];
    logic [4:0]    bil_reg,   bil_next,   bil_base, bil_inc;
    logic          first_reg, first_next, first_base, first_upd;
    logic          wait_reg,  wait_next,  wait_base,  wait_upd;
    logic          res_reg,   res_next,   res_base,   res_upd;
    logic [IW-1:0] len;
    logic          all_eq;
    logic          take;
    logic [7:0]    b;

    assign b    = stage.word.char_byte;
    assign take = stage.word.has_char;

    always_comb
    begin
        if (cfg.pattern_length == 5'd0)
        begin
            len = IW'(1);
        end
        else if (cfg.pattern_length > 5'(PATTERN_MAX))
        begin
            len = IW'(PATTERN_MAX);
        end
        else
        begin
            len = cfg.pattern_length[IW-1:0];
        end
    end

    // shifted window: newest byte at slot 0
    always_comb
    begin
        win_next[0] = b;
        for (int k = 1; k < DEPTH; k++)
        begin
            win_next[k] = win_reg[k-1];
        end
    end

    // pattern byte i lines up with window slot len-1-i
    always_comb
    begin
        logic [IW-1:0] idx;
        all_eq = 1'b1;
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            idx = IW'(int'(len) - 1 - i);
            if (i < int'(len))
            begin
                if (lsm_pkg::fold_byte(win_next[idx], cfg.ignore_case) !=
                    lsm_pkg::fold_byte(cfg.pattern[8*i +: 8], cfg.ignore_case))
                begin
                    all_eq = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        bil_base   = stage.word.new_file ? 5'd0 : bil_reg;
        first_base = stage.word.new_file ? 1'b0 : first_reg;
        wait_base  = stage.word.new_file ? 1'b0 : wait_reg;
        res_base   = stage.word.new_file ? 1'b0 : res_reg;

        bil_inc   = bil_base;
        first_upd = first_base;
        wait_upd  = wait_base;
        res_upd   = res_base;

        if (take)
        begin
            if (bil_base < lsm_pkg::BYTES_SAT)
            begin
                bil_inc = bil_base + 5'd1;
            end
            if (wait_base)
            begin
                res_upd  = (b == lsm_pkg::SPACE_BYTE);
                wait_upd = 1'b0;
            end
            else if (!first_base && bil_inc >= 5'(len) && all_eq)
            begin
                first_upd = 1'b1;
                // left edge is the line start or a space
                if (bil_inc == 5'(len) || win_next[len] == lsm_pkg::SPACE_BYTE)
                begin
                    wait_upd = 1'b1;
                end
                else
                begin
                    res_upd = 1'b0;
                end
            end
        end

        if (cfg.whole_word)
        begin
            hit = res_upd || wait_upd;
        end
        else
        begin
            hit = first_upd;
        end
        if (bil_inc == 5'd0)
        begin
            hit = 1'b0;
        end

        if (stage.word.line_end)
        begin
            bil_next   = 5'd0;
            first_next = 1'b0;
            wait_next  = 1'b0;
            res_next   = 1'b0;
        end
        else
        begin
            bil_next   = bil_inc;
            first_next = first_upd;
            wait_next  = wait_upd;
            res_next   = res_upd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage.step && take)
        begin
            for (int k = 0; k < DEPTH; k++)
            begin
                win_reg[k] <= win_next[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bil_reg   <= 5'd0;
            first_reg <= 1'b0;
            wait_reg  <= 1'b0;
            res_reg   <= 1'b0;
        end
        else if (stage.step)
        begin
            bil_reg   <= bil_next;
            first_reg <= first_next;
            wait_reg  <= wait_next;
            res_reg   <= res_next;
        end
    end

endmodule

/* design/lsm_count.sv */
`timescale 1ns / 1ps
// ============================================================================
// lsm_count
// Saturating line number and per-file match counters.
// ============================================================================
module lsm_count #(
    parameter int COUNT_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  lsm_pkg::stage_t     stage,
    input  logic                hit,
    output lsm_pkg::out_word_t  word
);

    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    logic [COUNT_BITS-1:0]    line_reg, line_base, line_next;
    logic [COUNT_BITS-1:0]    fm_reg,   fm_base,   fm_next;
    logic [COUNT_BITS+31:0]   line_wide, fm_wide;

    always_comb
    begin
        line_base = stage.word.new_file ? COUNT_BITS'(1) : line_reg;
        fm_base   = stage.word.new_file ? '0 : fm_reg;

        fm_next = fm_base;
        if (stage.word.line_end && hit && fm_base != CNT_MAX)
        begin
            fm_next = fm_base + COUNT_BITS'(1);
        end

        line_next = line_base;
        if (stage.word.line_end && line_base != CNT_MAX)
        begin
            line_next = line_base + COUNT_BITS'(1);
        end

        line_wide = {{32{1'b0}}, line_base};
        fm_wide   = {{32{1'b0}}, fm_next};

        word.matched     = hit;
        word.line_number = line_wide[31:0];
        word.match_count = fm_wide[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_reg <= COUNT_BITS'(1);
            fm_reg   <= '0;
        end
        else if (stage.step)
        begin
            line_reg <= line_next;
            fm_reg   <= fm_next;
        end
    end

endmodule

/* design/line_substring_matcher_core.sv */
`timescale 1ns / 1ps
// ============================================================================
// line_substring_matcher_core
// Fixed-string line matcher: one text byte per word, one result per line.
// ============================================================================
// A closed line reaches result_valid via the input register and the result register.
// Throughput: one word per cycle; the input register, the window compare
// and the result register form a two-stage pipeline that stalls only on
// result_ready.
// Reset: rst_n clears the pipeline, line state and counters (line number 1,
// count 0) and the registers (pattern zero, length 1, options off).
module line_substring_matcher_core #(
    parameter int PATTERN_MAX = 16,
    parameter int COUNT_BITS  = 32
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [lsm_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [lsm_pkg::CFG_DATA_W-1:0]         cfg_data,
    input  logic                                   item_valid,
    output logic                                   item_ready,
    input  lsm_pkg::in_word_t                      item,
    output logic                                   result_valid,
    input  logic                                   result_ready,
    output lsm_pkg::out_word_t                     result
);

    logic [63:0]        pat_low_reg, pat_high_reg;
    logic [4:0]         pat_len_reg;
    logic               icase_reg, wword_reg;
    lsm_pkg::cfg_t      cfg;

    logic               stage_valid_reg;
    lsm_pkg::in_word_t  item_reg;
    logic               advance;
    lsm_pkg::stage_t    stage;
    logic               hit;
    lsm_pkg::out_word_t line_word;

    logic               result_valid_reg;
    lsm_pkg::out_word_t result_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            pat_len_reg  <= 5'd1;
            icase_reg    <= 1'b0;
            wword_reg    <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                lsm_pkg::REG_PATTERN_LOW:  pat_low_reg  <= cfg_data;
                lsm_pkg::REG_PATTERN_HIGH: pat_high_reg <= cfg_data;
                lsm_pkg::REG_PATTERN_LEN:  pat_len_reg  <= cfg_data[4:0];
                lsm_pkg::REG_IGNORE_CASE:  icase_reg    <= cfg_data[0];
                lsm_pkg::REG_WHOLE_WORD:   wword_reg    <= cfg_data[0];
                default:                   ;
            endcase
        end
    end

    assign cfg.pattern        = {pat_high_reg, pat_low_reg};
    assign cfg.pattern_length = pat_len_reg;
    assign cfg.ignore_case    = icase_reg;
    assign cfg.whole_word     = wword_reg;

    // advance the pipe whenever the result slot is free or being drained
    assign advance    = !result_valid_reg || result_ready;
    assign item_ready = !stage_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (item_valid && item_ready)
        begin
            stage_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            stage_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            item_reg <= item;
        end
    end

    assign stage.step = stage_valid_reg && advance;
    assign stage.word = item_reg;

    lsm_match #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_match (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .stage (stage),
        .hit   (hit)
    );

    lsm_count #(
        .COUNT_BITS (COUNT_BITS)
    ) u_count (
        .clk   (clk),
        .rst_n (rst_n),
        .stage (stage),
        .hit   (hit),
        .word  (line_word)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            result_valid_reg <= stage_valid_reg && item_reg.line_end;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage.step && item_reg.line_end)
        begin
            result_reg <= line_word;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef SYNTHESIS
    a_close_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        stage.step && item_reg.line_end |=> result_valid)
        else $error("closed line produced no result");

    a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
        stage.step && !item_reg.line_end |=> !result_valid)
        else $error("result without a closed line");

    a_match_counted: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.matched |-> result.match_count != 32'd0)
        else $error("matched line with zero match count");

    a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.line_number != 32'd0)
        else $error("line number zero");

    a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> item_ready)
        else $error("input stalled with empty result slot");
`endif

endmodule
